// ===== hdl/tfr_pkg.sv =====
// Shared widths, types, constants and helper functions for the trilateration block.
// Used by tfr_div_cell, tfr_sqrt_cell and trilateration_from_three_ranges.
package tfr_pkg;

  localparam int RANGE_BITS = 20;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_BITS   = 24;

  localparam int SQ_W    = 2 * RANGE_BITS;
  localparam int COMBO_W = SQ_W + 1;
  localparam int A2X_W   = RANGE_BITS + FRAC_BITS;
  localparam int A2Y_W   = A2X_W;
  localparam int XQ_W    = OUT_BITS + FRAC_BITS;
  localparam int RAD_W   = 2 * A2X_W;
  localparam int DEN_W   = A2Y_W + 1;
  localparam int PROD_W  = XQ_W + A2X_W;
  localparam int XNUM_W  = COMBO_W + FRAC_BITS;
  localparam int NYA_W   = COMBO_W + 2 * FRAC_BITS;
  localparam int NYB_W   = PROD_W + 1;
  localparam int NY_W    = ((NYA_W > NYB_W) ? NYA_W : NYB_W) + 1;
  localparam int NUM_W   = (NY_W > XNUM_W) ? NY_W : XNUM_W;

  localparam logic [1:0] REG_DIST_A0_A1 = 2'd0;
  localparam logic [1:0] REG_DIST_A1_A2 = 2'd1;
  localparam logic [1:0] REG_DIST_A0_A2 = 2'd2;

  typedef logic [RANGE_BITS-1:0]    range_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic signed [COMBO_W:0]  sc_t;
  typedef logic [NUM_W-1:0]         num_t;
  typedef logic signed [NUM_W:0]    sum_t;
  typedef logic [DEN_W-1:0]         den_t;
  typedef logic [A2X_W-1:0]         a2x_t;
  typedef logic [A2Y_W-1:0]         root_t;
  typedef logic [A2Y_W:0]           srem_t;
  typedef logic [XQ_W-1:0]          xq_t;
  typedef logic [RAD_W-1:0]         rad_t;
  typedef logic [PROD_W-1:0]        prod_t;
  typedef logic signed [OUT_BITS-1:0] out_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_TRI  = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  localparam num_t POS_LIM = num_t'((64'd1 << (OUT_BITS - 1)) - 64'd1);
  localparam num_t NEG_LIM = num_t'(64'd1 << (OUT_BITS - 1));

  typedef struct packed {
    num_t num;
    num_t quo;
    den_t rem;
    den_t den;
  } div_t;

  typedef struct packed {
    rad_t  rad;
    root_t root;
    srem_t rem;
  } sqrt_t;

  function automatic sc_t combo(input sq_t a, input sq_t b, input sq_t c);
    combo = sc_t'(a) - sc_t'(b) + sc_t'(c);
  endfunction

  function automatic num_t mag_of(input sc_t v);
    mag_of = v[COMBO_W] ? num_t'(-v) : num_t'(v);
  endfunction

endpackage

// ===== hdl/tfr_div_cell.sv =====
// One restoring division step: brings down a numerator bit, develops one quotient bit.
// Depends on tfr_pkg for widths and the div_t struct.
module tfr_div_cell (
  input  logic          clk,
  input  logic          en,
  input  tfr_pkg::div_t d,
  output tfr_pkg::div_t q
);

  logic [tfr_pkg::DEN_W:0] sh;
  logic [tfr_pkg::DEN_W:0] diff;
  logic                    ge;
  tfr_pkg::div_t           nxt;

  always_comb begin
    sh       = {d.rem, d.num[tfr_pkg::NUM_W-1]};
    diff     = sh - {1'b0, d.den};
    ge       = (sh >= {1'b0, d.den});
    nxt.num  = d.num << 1;
    nxt.quo  = {d.quo[tfr_pkg::NUM_W-2:0], ge};
    nxt.rem  = ge ? diff[tfr_pkg::DEN_W-1:0] : sh[tfr_pkg::DEN_W-1:0];
    nxt.den  = d.den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

// ===== hdl/tfr_sqrt_cell.sv =====
// One digit-by-digit square root step: takes two radicand bits, develops one root bit.
// Depends on tfr_pkg for widths and the sqrt_t struct.
module tfr_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  tfr_pkg::sqrt_t d,
  output tfr_pkg::sqrt_t q
);

  logic [tfr_pkg::A2Y_W+2:0] cur;
  logic [tfr_pkg::A2Y_W+2:0] trial;
  logic [tfr_pkg::A2Y_W+2:0] diff;
  logic                      ge;
  tfr_pkg::sqrt_t            nxt;

  always_comb begin
    cur      = {d.rem, d.rad[tfr_pkg::RAD_W-1 -: 2]};
    trial    = {1'b0, d.root, 2'b01};
    diff     = cur - trial;
    ge       = (cur >= trial);
    nxt.rad  = d.rad << 2;
    nxt.root = {d.root[tfr_pkg::A2Y_W-2:0], ge};
    nxt.rem  = ge ? diff[tfr_pkg::A2Y_W:0] : cur[tfr_pkg::A2Y_W:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

// ===== hdl/trilateration_from_three_ranges.sv =====
// Top level: 2D trilateration from three ranges, anchor registers and the cell pipeline.
// Depends on tfr_pkg, tfr_div_cell and tfr_sqrt_cell.
//
// Takes one range set per cycle while the row is not held and returns one position per
// range set, in order. The path runs through the squaring and sum registers, a row
// of 62 division cells for a2x and x, the clamping and product registers, a row of
// 28 square root cells for a2y, a row of 62 division cells for y and the output
// register. The anchor position is derived again for every range set from the anchor
// registers, so no settling time follows a register write. The whole row holds only
// when the output register is full and not taken while a result reaches it.
module trilateration_from_three_ranges (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tfr_pkg::RANGE_BITS-1:0]   range_a0,
  input  logic [tfr_pkg::RANGE_BITS-1:0]   range_a1,
  input  logic [tfr_pkg::RANGE_BITS-1:0]   range_a2,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [tfr_pkg::OUT_BITS-1:0] pos_x,
  output logic signed [tfr_pkg::OUT_BITS-1:0] pos_y,
  output logic [1:0]                       status,
  input  logic                             cfg_write,
  input  logic [1:0]                       cfg_index,
  input  logic [tfr_pkg::RANGE_BITS-1:0]   cfg_data
);

  typedef struct packed {
    logic             zero;
    tfr_pkg::range_t  d02;
    tfr_pkg::sq_t     sq_d02;
    logic             na_neg;
    logic             nx_neg;
    tfr_pkg::sc_t     nyb;
  } side1_t;

  typedef struct packed {
    logic             zero;
    logic             bad;
    logic             xsat;
    tfr_pkg::out_t    px;
    logic             ny_neg;
    tfr_pkg::num_t    ny_mag;
  } side2_t;

  typedef struct packed {
    logic             zero;
    logic             bad;
    logic             xsat;
    tfr_pkg::out_t    px;
    logic             ny_neg;
  } side3_t;

  tfr_pkg::range_t dist_a0_a1;
  tfr_pkg::range_t dist_a1_a2;
  tfr_pkg::range_t dist_a0_a2;

  logic en;
  logic last_valid;

  // stage 1: squares
  logic            v1;
  tfr_pkg::sq_t    sq_d01, sq_d12, sq_d02, sq_r0, sq_r1, sq_r2;
  tfr_pkg::range_t d01_1, d02_1;

  // stage 2: signed sums
  logic            v2;
  tfr_pkg::sc_t    na, nx, nyb;
  tfr_pkg::range_t d01_2, d02_2;
  tfr_pkg::sq_t    sq_d02_2;

  // division row one
  tfr_pkg::div_t a_entry, x_entry;
  tfr_pkg::div_t a_chain [tfr_pkg::NUM_W];
  tfr_pkg::div_t x_chain [tfr_pkg::NUM_W];
  side1_t        side1_entry;
  side1_t        side1 [tfr_pkg::NUM_W];
  logic [tfr_pkg::NUM_W-1:0] v_div1;

  // stage 3: checks and clamp of x
  tfr_pkg::num_t a2x_q, x_q, x_mm, x_lim, x_mm_sel;
  logic          x_sat_c;
  logic          v3, zero3, bad3, xsat3, a2x_neg3, xneg3;
  tfr_pkg::a2x_t a2x3;
  tfr_pkg::xq_t  xq3;
  tfr_pkg::out_t px3;
  tfr_pkg::sq_t  sq_d02_3;
  tfr_pkg::sc_t  nyb3;

  // stage 4: products
  logic           v4, zero4, bad4, xsat4, prod_pos4;
  tfr_pkg::out_t  px4;
  tfr_pkg::sq_t   sq_d02_4;
  tfr_pkg::sc_t   nyb4;
  tfr_pkg::rad_t  a2x_sq4;
  tfr_pkg::prod_t prod4;

  // stage 5: radicand and y numerator
  tfr_pkg::sum_t  p2;
  logic           v5, zero5, bad5, xsat5;
  tfr_pkg::out_t  px5;
  tfr_pkg::rad_t  rad5;
  tfr_pkg::sum_t  ny5;

  // square root row
  tfr_pkg::sqrt_t s_entry;
  tfr_pkg::sqrt_t s_chain [tfr_pkg::A2Y_W];
  side2_t         side2_entry;
  side2_t         side2 [tfr_pkg::A2Y_W];
  logic [tfr_pkg::A2Y_W-1:0] v_sq;

  // division row two
  tfr_pkg::div_t y_entry;
  tfr_pkg::div_t y_chain [tfr_pkg::NUM_W];
  side3_t        side3_entry;
  side3_t        side3 [tfr_pkg::NUM_W];
  logic [tfr_pkg::NUM_W-1:0] v_div2;

  // output
  tfr_pkg::num_t    y_q, y_mm, y_lim, y_mm_sel;
  logic             y_sat_c;
  side3_t           fin;
  tfr_pkg::out_t    px_o, py_o;
  tfr_pkg::status_t st_o, st_reg;

  assign last_valid = v_div2[tfr_pkg::NUM_W-1];
  assign en         = !out_valid || out_ready || !last_valid;
  assign in_ready   = en;
  assign status     = st_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_a0_a1 <= '0;
      dist_a1_a2 <= '0;
      dist_a0_a2 <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        tfr_pkg::REG_DIST_A0_A1: dist_a0_a1 <= cfg_data;
        tfr_pkg::REG_DIST_A1_A2: dist_a1_a2 <= cfg_data;
        tfr_pkg::REG_DIST_A0_A2: dist_a0_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v_div1[tfr_pkg::NUM_W-1];
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_d01 <= tfr_pkg::sq_t'(dist_a0_a1 * dist_a0_a1);
      sq_d12 <= tfr_pkg::sq_t'(dist_a1_a2 * dist_a1_a2);
      sq_d02 <= tfr_pkg::sq_t'(dist_a0_a2 * dist_a0_a2);
      sq_r0  <= tfr_pkg::sq_t'(range_a0 * range_a0);
      sq_r1  <= tfr_pkg::sq_t'(range_a1 * range_a1);
      sq_r2  <= tfr_pkg::sq_t'(range_a2 * range_a2);
      d01_1  <= dist_a0_a1;
      d02_1  <= dist_a0_a2;

      na       <= tfr_pkg::combo(sq_d02, sq_d12, sq_d01);
      nx       <= tfr_pkg::combo(sq_r0, sq_r1, sq_d01);
      nyb      <= tfr_pkg::combo(sq_r0, sq_r2, sq_d02);
      d01_2    <= d01_1;
      d02_2    <= d02_1;
      sq_d02_2 <= sq_d02;
    end
  end

  always_comb begin
    a_entry.num = tfr_pkg::mag_of(na) << tfr_pkg::FRAC_BITS;
    a_entry.quo = '0;
    a_entry.rem = '0;
    a_entry.den = tfr_pkg::den_t'(d01_2) << 1;
    x_entry.num = tfr_pkg::mag_of(nx) << tfr_pkg::FRAC_BITS;
    x_entry.quo = '0;
    x_entry.rem = '0;
    x_entry.den = tfr_pkg::den_t'(d01_2) << 1;
    side1_entry.zero   = (d01_2 == '0);
    side1_entry.d02    = d02_2;
    side1_entry.sq_d02 = sq_d02_2;
    side1_entry.na_neg = na[tfr_pkg::COMBO_W];
    side1_entry.nx_neg = nx[tfr_pkg::COMBO_W];
    side1_entry.nyb    = nyb;
  end

  for (genvar k = 0; k < tfr_pkg::NUM_W; k++) begin : g_div1
    if (k == 0) begin : g_head
      tfr_div_cell u_a (.clk(clk), .en(en), .d(a_entry), .q(a_chain[k]));
      tfr_div_cell u_x (.clk(clk), .en(en), .d(x_entry), .q(x_chain[k]));
    end else begin : g_body
      tfr_div_cell u_a (.clk(clk), .en(en), .d(a_chain[k-1]), .q(a_chain[k]));
      tfr_div_cell u_x (.clk(clk), .en(en), .d(x_chain[k-1]), .q(x_chain[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_div1 <= '0;
    end else if (en) begin
      v_div1 <= {v_div1[tfr_pkg::NUM_W-2:0], v2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1[0] <= side1_entry;
      for (int i = 1; i < tfr_pkg::NUM_W; i++) begin
        side1[i] <= side1[i-1];
      end
    end
  end

  always_comb begin
    a2x_q    = a_chain[tfr_pkg::NUM_W-1].quo;
    x_q      = x_chain[tfr_pkg::NUM_W-1].quo;
    x_mm     = x_q >> tfr_pkg::FRAC_BITS;
    x_lim    = side1[tfr_pkg::NUM_W-1].nx_neg ? tfr_pkg::NEG_LIM : tfr_pkg::POS_LIM;
    x_sat_c  = (x_mm > x_lim);
    x_mm_sel = x_sat_c ? x_lim : x_mm;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero3    <= side1[tfr_pkg::NUM_W-1].zero;
      bad3     <= (a2x_q > (tfr_pkg::num_t'(side1[tfr_pkg::NUM_W-1].d02)
                            << tfr_pkg::FRAC_BITS));
      a2x3     <= a2x_q[tfr_pkg::A2X_W-1:0];
      a2x_neg3 <= side1[tfr_pkg::NUM_W-1].na_neg;
      xneg3    <= side1[tfr_pkg::NUM_W-1].nx_neg;
      xsat3    <= x_sat_c;
      xq3      <= x_sat_c ? tfr_pkg::xq_t'(x_lim << tfr_pkg::FRAC_BITS)
                          : x_q[tfr_pkg::XQ_W-1:0];
      px3      <= side1[tfr_pkg::NUM_W-1].nx_neg ? tfr_pkg::out_t'(-x_mm_sel)
                                                 : tfr_pkg::out_t'(x_mm_sel);
      sq_d02_3 <= side1[tfr_pkg::NUM_W-1].sq_d02;
      nyb3     <= side1[tfr_pkg::NUM_W-1].nyb;

      zero4     <= zero3;
      bad4      <= bad3;
      xsat4     <= xsat3;
      px4       <= px3;
      sq_d02_4  <= sq_d02_3;
      nyb4      <= nyb3;
      a2x_sq4   <= tfr_pkg::rad_t'(a2x3 * a2x3);
      prod4     <= tfr_pkg::prod_t'(xq3 * a2x3);
      prod_pos4 <= xneg3 ^ a2x_neg3;

      zero5 <= zero4;
      bad5  <= bad4;
      xsat5 <= xsat4;
      px5   <= px4;
      rad5  <= (tfr_pkg::rad_t'(sq_d02_4) << (2 * tfr_pkg::FRAC_BITS)) - a2x_sq4;
      ny5   <= (tfr_pkg::sum_t'(nyb4) <<< (2 * tfr_pkg::FRAC_BITS))
               + (prod_pos4 ? p2 : -p2);
    end
  end

  assign p2 = tfr_pkg::sum_t'(prod4) << 1;

  always_comb begin
    s_entry.rad  = rad5;
    s_entry.root = '0;
    s_entry.rem  = '0;
    side2_entry.zero   = zero5;
    side2_entry.bad    = bad5;
    side2_entry.xsat   = xsat5;
    side2_entry.px     = px5;
    side2_entry.ny_neg = ny5[tfr_pkg::NUM_W];
    side2_entry.ny_mag = ny5[tfr_pkg::NUM_W] ? tfr_pkg::num_t'(-ny5) : tfr_pkg::num_t'(ny5);
  end

  for (genvar k = 0; k < tfr_pkg::A2Y_W; k++) begin : g_sqrt
    if (k == 0) begin : g_head
      tfr_sqrt_cell u_s (.clk(clk), .en(en), .d(s_entry), .q(s_chain[k]));
    end else begin : g_body
      tfr_sqrt_cell u_s (.clk(clk), .en(en), .d(s_chain[k-1]), .q(s_chain[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sq <= '0;
    end else if (en) begin
      v_sq <= {v_sq[tfr_pkg::A2Y_W-2:0], v5};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2[0] <= side2_entry;
      for (int i = 1; i < tfr_pkg::A2Y_W; i++) begin
        side2[i] <= side2[i-1];
      end
    end
  end

  always_comb begin
    y_entry.num = side2[tfr_pkg::A2Y_W-1].ny_mag;
    y_entry.quo = '0;
    y_entry.rem = '0;
    y_entry.den = tfr_pkg::den_t'(s_chain[tfr_pkg::A2Y_W-1].root) << 1;
    side3_entry.zero   = side2[tfr_pkg::A2Y_W-1].zero;
    side3_entry.bad    = side2[tfr_pkg::A2Y_W-1].bad
                         || (s_chain[tfr_pkg::A2Y_W-1].root == '0);
    side3_entry.xsat   = side2[tfr_pkg::A2Y_W-1].xsat;
    side3_entry.px     = side2[tfr_pkg::A2Y_W-1].px;
    side3_entry.ny_neg = side2[tfr_pkg::A2Y_W-1].ny_neg;
  end

  for (genvar k = 0; k < tfr_pkg::NUM_W; k++) begin : g_div2
    if (k == 0) begin : g_head
      tfr_div_cell u_y (.clk(clk), .en(en), .d(y_entry), .q(y_chain[k]));
    end else begin : g_body
      tfr_div_cell u_y (.clk(clk), .en(en), .d(y_chain[k-1]), .q(y_chain[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_div2 <= '0;
    end else if (en) begin
      v_div2 <= {v_div2[tfr_pkg::NUM_W-2:0], v_sq[tfr_pkg::A2Y_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3[0] <= side3_entry;
      for (int i = 1; i < tfr_pkg::NUM_W; i++) begin
        side3[i] <= side3[i-1];
      end
    end
  end

  always_comb begin
    fin      = side3[tfr_pkg::NUM_W-1];
    y_q      = y_chain[tfr_pkg::NUM_W-1].quo;
    y_mm     = y_q >> tfr_pkg::FRAC_BITS;
    y_lim    = fin.ny_neg ? tfr_pkg::NEG_LIM : tfr_pkg::POS_LIM;
    y_sat_c  = (y_mm > y_lim);
    y_mm_sel = y_sat_c ? y_lim : y_mm;
    px_o     = fin.px;
    py_o     = fin.ny_neg ? tfr_pkg::out_t'(-y_mm_sel) : tfr_pkg::out_t'(y_mm_sel);
    st_o     = tfr_pkg::ST_OK;
    if (fin.zero) begin
      st_o = tfr_pkg::ST_ZERO;
      px_o = '0;
      py_o = '0;
    end else if (fin.bad) begin
      st_o = tfr_pkg::ST_TRI;
      px_o = '0;
      py_o = '0;
    end else if (fin.xsat || y_sat_c) begin
      st_o = tfr_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!out_valid || out_ready) && last_valid) begin
      pos_x  <= px_o;
      pos_y  <= py_o;
      st_reg <= st_o;
    end
  end

`ifndef SYNTHESIS
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && last_valid))
    else $error("input held without a blocked result");

  a_drain : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_valid) |=> !out_valid)
    else $error("result repeated after it was taken");

  a_fault_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (st_reg == tfr_pkg::ST_ZERO || st_reg == tfr_pkg::ST_TRI))
      |-> (pos_x == '0 && pos_y == '0))
    else $error("fault status with nonzero position");

  a_load : assert property (@(posedge clk) disable iff (rst)
    (last_valid && (!out_valid || out_ready)) |=> out_valid)
    else $error("finished request lost at the output");
`endif

endmodule

// ===== tb/tb_trilateration_from_three_ranges.sv =====
// Testbench for trilateration_from_three_ranges: directed table, then random anchor
// setups and range sets, checked in order against the table or a fixed-point predictor.
// Depends on tfr_pkg and the trilateration_from_three_ranges RTL.
module tb_trilateration_from_three_ranges;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    tfr_pkg::out_t    x;
    tfr_pkg::out_t    y;
    tfr_pkg::status_t st;
  } pos_t;

  typedef struct {
    tfr_pkg::range_t d01, d12, d02;
    tfr_pkg::range_t r0, r1, r2;
    bit              typed;
    pos_t            want;
  } row_t;

  localparam tfr_pkg::range_t RMAX = {tfr_pkg::RANGE_BITS{1'b1}};

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  tfr_pkg::range_t range_a0 = '0, range_a1 = '0, range_a2 = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  tfr_pkg::out_t pos_x, pos_y;
  logic [1:0] status;
  logic   cfg_write = 1'b0;
  logic [1:0] cfg_index = tfr_pkg::REG_DIST_A0_A1;
  tfr_pkg::range_t cfg_data = '0;

  pos_t   pending_pos[$];
  tfr_pkg::range_t anc01 = '0, anc12 = '0, anc02 = '0;
  int     mismatches = 0;
  int     requests = 0;
  int     positions = 0;
  int     anchor_setups = 0;
  bit     calm = 1'b0;
  row_t   rows[$];

  trilateration_from_three_ranges uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .range_a0(range_a0), .range_a1(range_a1), .range_a2(range_a2),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic wide_t sq(input tfr_pkg::range_t v);
    sq = wide_t'(v) * wide_t'(v);
  endfunction

  function automatic tfr_pkg::out_t to_mm(inout wide_t mag, input bit neg, inout bit sat);
    wide_t w, lim;
    w = mag >>> tfr_pkg::FRAC_BITS;
    lim = neg ? (wide_t'(1) <<< (tfr_pkg::OUT_BITS - 1))
              : (wide_t'(1) <<< (tfr_pkg::OUT_BITS - 1)) - 1;
    if (w > lim) begin
      sat = 1'b1;
      w = lim;
      mag = w <<< tfr_pkg::FRAC_BITS;
    end
    to_mm = tfr_pkg::out_t'(neg ? -w : w);
  endfunction

  function automatic pos_t locate(input tfr_pkg::range_t r0, r1, r2, d01, d12, d02);
    wide_t na, a2x_m, den, rad, t, a2y, nx, xm, ny, ym, xs, a2xs;
    bit a2x_n, xn, yn, sat;
    pos_t p;
    p.x = '0;
    p.y = '0;
    p.st = tfr_pkg::ST_OK;
    sat = 1'b0;
    if (d01 == 0) begin
      p.st = tfr_pkg::ST_ZERO;
      return p;
    end
    den = wide_t'(d01) * 2;
    na = sq(d02) - sq(d12) + sq(d01);
    a2x_n = na < 0;
    a2x_m = ((a2x_n ? -na : na) <<< tfr_pkg::FRAC_BITS) / den;
    if (a2x_m > (wide_t'(d02) <<< tfr_pkg::FRAC_BITS)) begin
      p.st = tfr_pkg::ST_TRI;
      return p;
    end
    rad = (sq(d02) <<< (2 * tfr_pkg::FRAC_BITS)) - a2x_m * a2x_m;
    a2y = 0;
    for (int b = 40; b >= 0; b--) begin
      t = a2y | (wide_t'(1) <<< b);
      if (t * t <= rad) a2y = t;
    end
    if (a2y == 0) begin
      p.st = tfr_pkg::ST_TRI;
      return p;
    end
    nx = sq(r0) - sq(r1) + sq(d01);
    xn = nx < 0;
    xm = ((xn ? -nx : nx) <<< tfr_pkg::FRAC_BITS) / den;
    p.x = to_mm(xm, xn, sat);
    xs = xn ? -xm : xm;
    a2xs = a2x_n ? -a2x_m : a2x_m;
    ny = ((sq(r0) - sq(r2) + sq(d02)) <<< (2 * tfr_pkg::FRAC_BITS)) - 2 * xs * a2xs;
    yn = ny < 0;
    ym = (yn ? -ny : ny) / (2 * a2y);
    p.y = to_mm(ym, yn, sat);
    p.st = sat ? tfr_pkg::ST_SAT : tfr_pkg::ST_OK;
    return p;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic set_anchors(input tfr_pkg::range_t d01, d12, d02);
    wait (pending_pos.size() == 0);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= tfr_pkg::REG_DIST_A0_A1;
    cfg_data  <= d01;
    @(negedge clk);
    cfg_index <= tfr_pkg::REG_DIST_A1_A2;
    cfg_data  <= d12;
    @(negedge clk);
    cfg_index <= tfr_pkg::REG_DIST_A0_A2;
    cfg_data  <= d02;
    @(negedge clk);
    cfg_write <= 1'b0;
    anc01 = d01;
    anc12 = d12;
    anc02 = d02;
    anchor_setups++;
  endtask

  // called at a falling edge; returns at a falling edge with the request taken
  task automatic send(input tfr_pkg::range_t r0, r1, r2, input bit typed, input pos_t want);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    range_a0 <= r0;
    range_a1 <= r1;
    range_a2 <= r2;
    do @(posedge clk); while (!in_ready);
    pending_pos.push_back(typed ? want : locate(r0, r1, r2, anc01, anc12, anc02));
    requests++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin : sink_pace
    int left;
    bit stall;
    if (rst || calm) begin
      out_ready <= !rst;
      left = 0;
    end else begin
      if (left == 0) begin
        stall = $urandom_range(0, 3) == 0;
        left = stall ? $urandom_range(1, 7) : $urandom_range(1, 20);
      end
      out_ready <= !stall;
      left--;
    end
  end

  always @(posedge clk) begin
    pos_t w;
    if (!rst && out_valid && out_ready) begin
      positions++;
      if (pending_pos.size() == 0) begin
        report("unexpected position, x", pos_x, 0);
      end else begin
        w = pending_pos.pop_front();
        if (pos_x !== w.x) report("pos_x", pos_x, w.x);
        if (pos_y !== w.y) report("pos_y", pos_y, w.y);
        if (status !== w.st) report("status", status, w.st);
      end
    end
  end

  function automatic row_t mk(input tfr_pkg::range_t d01, d12, d02, r0, r1, r2,
                              input bit typed = 1'b0,
                              input tfr_pkg::status_t st = tfr_pkg::ST_OK);
    row_t r;
    r.d01 = d01; r.d12 = d12; r.d02 = d02;
    r.r0 = r0; r.r1 = r1; r.r2 = r2;
    r.typed = typed;
    r.want.x = '0;
    r.want.y = '0;
    r.want.st = st;
    return r;
  endfunction

  function automatic tfr_pkg::range_t near(input tfr_pkg::range_t span);
    int unsigned m;
    m = $urandom_range(0, 9);
    if (m < 6) return tfr_pkg::range_t'($urandom_range(0, 2 * span + 16));
    if (m < 8) return tfr_pkg::range_t'($urandom());
    return (m == 8) ? '0 : RMAX;
  endfunction

  initial begin
    tfr_pkg::range_t d01, d12, d02, s, lo, hi;
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, tfr_pkg::ST_ZERO));
    rows.push_back(mk(0, 0, 0, RMAX, RMAX, RMAX, 1, tfr_pkg::ST_ZERO));
    rows.push_back(mk(0, 0, 0, 'h55555, 'hAAAAA, 'h12345, 1, tfr_pkg::ST_ZERO));
    rows.push_back(mk(1000, 1000, 3000, 500, 700, 900, 1, tfr_pkg::ST_TRI));
    rows.push_back(mk(1000, 1000, 2000, 500, 700, 900, 1, tfr_pkg::ST_TRI));
    rows.push_back(mk(3000, 5000, 4000, 0, 0, 0));
    rows.push_back(mk(3000, 5000, 4000, 3000, 0, 5000));
    rows.push_back(mk(3000, 5000, 4000, RMAX, 0, 0));
    rows.push_back(mk(3000, 5000, 4000, 0, RMAX, 0));
    rows.push_back(mk(3000, 5000, 4000, 0, 0, RMAX));
    rows.push_back(mk(3000, 5000, 4000, 2000, 2000, 2000));
    rows.push_back(mk(3000, 5000, 4000, RMAX, RMAX, RMAX));
    rows.push_back(mk(3000, 5000, 4000, 5000, 4000, 3000));
    rows.push_back(mk(RMAX, RMAX, RMAX, 0, 0, 0));
    rows.push_back(mk(RMAX, RMAX, RMAX, RMAX, RMAX, RMAX));
    rows.push_back(mk(RMAX, RMAX, RMAX, RMAX, 0, RMAX));
    rows.push_back(mk(RMAX, RMAX, RMAX, 1, RMAX, 1));
    rows.push_back(mk(1, 1, 1, 1, 1, 1));
    rows.push_back(mk(1, 1, 1, 0, 0, 0));
    rows.push_back(mk(1, 1, 1, RMAX, 0, 0));
    rows.push_back(mk(0, 5, 5, 3, 4, 5, 1, tfr_pkg::ST_ZERO));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].d01 != anc01 || rows[i].d12 != anc12 || rows[i].d02 != anc02) begin
        in_valid <= 1'b0;
        set_anchors(rows[i].d01, rows[i].d12, rows[i].d02);
      end
      send(rows[i].r0, rows[i].r1, rows[i].r2, rows[i].typed, rows[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      s = ($urandom_range(0, 2) == 0) ? RMAX : tfr_pkg::range_t'($urandom_range(16, 4095));
      d01 = tfr_pkg::range_t'($urandom_range(1, s));
      d02 = tfr_pkg::range_t'($urandom_range(1, s));
      lo = (d01 > d02) ? d01 - d02 : d02 - d01;
      hi = (int'(d01) + int'(d02) > int'(RMAX)) ? RMAX : tfr_pkg::range_t'(d01 + d02);
      d12 = ($urandom_range(0, 4) == 0) ? tfr_pkg::range_t'($urandom())
                                        : tfr_pkg::range_t'($urandom_range(lo, hi));
      if (ph == 5) d01 = '0;
      if (ph == 7) calm = 1'b1;
      in_valid <= 1'b0;
      set_anchors(d01, d12, d02);
      repeat (116) send(near(s), near(s), near(s), 1'b0, '{'0, '0, tfr_pkg::ST_OK});
    end
    in_valid <= 1'b0;

    wait (pending_pos.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d range sets over %0d anchor setups, %0d positions checked",
             requests, anchor_setups, positions);
    if (mismatches == 0 && pending_pos.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tfr_pkg.sv
hdl/tfr_div_cell.sv
hdl/tfr_sqrt_cell.sv
hdl/trilateration_from_three_ranges.sv
tb/tb_trilateration_from_three_ranges.sv
